// ===== rtl/core/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared constants, codes, control/status types and helpers for the
// nearest peak cost merging core.
// ----------------------------------------------------------------------------
package npcm_pkg;

	localparam int MAX_PEAKS     = 64;
	localparam int MAX_MUTATIONS = 64;
	localparam int PEAK_AW       = $clog2(MAX_PEAKS);
	localparam int MUT_AW        = $clog2(MAX_MUTATIONS);

	localparam int COST_W = 32;
	localparam int POS_W  = 24;
	localparam int ALL_W  = 8;
	localparam int DESC_W = POS_W + ALL_W;
	localparam int MASK_W = 64;
	localparam int CNT_W  = 7;
	localparam int DIST_W = 8;
	localparam int CFG_IW = 2;

	// input commands
	localparam logic [1:0] CMD_LOAD_DESC = 2'd0;
	localparam logic [1:0] CMD_LOAD_PEAK = 2'd1;
	localparam logic [1:0] CMD_RUN       = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_EPS   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_PEAKS = 2'd1;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE     = 5'd0;
	localparam op_t OP_LOAD     = 5'd1;
	localparam op_t OP_SORT_RDI = 5'd2;
	localparam op_t OP_SORT_LTI = 5'd3;
	localparam op_t OP_SORT_RDJ = 5'd4;
	localparam op_t OP_SORT_CMP = 5'd5;
	localparam op_t OP_SORT_WR  = 5'd6;
	localparam op_t OP_N_RDRI   = 5'd7;
	localparam op_t OP_N_RDMI   = 5'd8;
	localparam op_t OP_N_LTMI   = 5'd9;
	localparam op_t OP_N_RDRJ   = 5'd10;
	localparam op_t OP_N_RDMJ   = 5'd11;
	localparam op_t OP_N_LTMJ   = 5'd12;
	localparam op_t OP_W_ISSUE  = 5'd13;
	localparam op_t OP_W_STEP   = 5'd14;
	localparam op_t OP_N_UPD    = 5'd15;
	localparam op_t OP_M_RDC    = 5'd16;
	localparam op_t OP_M_CHK    = 5'd17;
	localparam op_t OP_M_DIV    = 5'd18;
	localparam op_t OP_M_ISSUE  = 5'd19;
	localparam op_t OP_M_ADD    = 5'd20;
	localparam op_t OP_M_ZERO   = 5'd21;
	localparam op_t OP_M_NEXT   = 5'd22;
	localparam op_t OP_O_RD     = 5'd23;
	localparam op_t OP_O_LAT    = 5'd24;
	localparam op_t OP_O_WAIT   = 5'd25;

	typedef struct packed {
		op_t  op;
	} ctl_t;

	typedef struct packed {
		logic run_start;
		logic n_zero;
		logic n_one;
		logic j_end;
		logic i_last;
		logic walk_done;
		logic skip;
		logic div_done;
		logic set_empty;
		logic merge_last;
		logic out_fire;
		logic out_last;
	} sts_t;

	// index of lowest set bit, zero when none
	function automatic logic [MUT_AW-1:0] low_idx(input logic [MASK_W-1:0] v);
		logic [MUT_AW-1:0] r;
		r = '0;
		for (int b = MASK_W - 1; b >= 0; b--) begin
			if (v[b]) r = MUT_AW'(b);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/npcm_if.sv =====
// ----------------------------------------------------------------------------
// npcm_if
// Valid/ready channels of the core: load/run requests, results, config writes.
// ----------------------------------------------------------------------------
interface npcm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  item_index;
	logic [23:0] position;
	logic [7:0]  allele;
	logic [31:0] cost;
	logic [63:0] mutation_mask;
	modport source (output valid, cmd, item_index, position, allele, cost, mutation_mask,
		input ready);
	modport sink (input valid, cmd, item_index, position, allele, cost, mutation_mask,
		output ready);
endinterface

interface npcm_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  peak_index;
	logic [31:0] new_cost;
	logic        last;
	modport source (output valid, peak_index, new_cost, last, input ready);
	modport sink (input valid, peak_index, new_cost, last, output ready);
endinterface

interface npcm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/npcm_ram.sv =====
// ----------------------------------------------------------------------------
// npcm_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/npcm_div.sv =====
// ----------------------------------------------------------------------------
// npcm_div
// Restoring divider, one quotient bit per cycle: cost / member count.
// ----------------------------------------------------------------------------
module npcm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [npcm_pkg::COST_W-1:0] dividend,
	input  logic [npcm_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [npcm_pkg::COST_W-1:0] quot
);

	localparam int SW = $clog2(npcm_pkg::COST_W);

	logic                        busy_q;
	logic                        done_q;
	logic [SW-1:0]               cnt_q;
	logic [npcm_pkg::COST_W-1:0] q_q;
	logic [npcm_pkg::CNT_W-1:0]  div_q;
	logic [npcm_pkg::CNT_W-1:0]  rem_q;
	logic [npcm_pkg::CNT_W:0]    shifted;
	logic                        ge;

	assign shifted = {rem_q, q_q[npcm_pkg::COST_W-1]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(npcm_pkg::COST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? npcm_pkg::CNT_W'(shifted - {1'b0, div_q})
			            : npcm_pkg::CNT_W'(shifted);
			q_q   <= {q_q[npcm_pkg::COST_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== rtl/core/npcm_datapath.sv =====
// ----------------------------------------------------------------------------
// npcm_datapath
// Stores, counters, distance walk, merge arithmetic and the result register.
// Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module npcm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	npcm_in_if.sink             item,
	npcm_out_if.source          result,
	npcm_cfg_if.sink            cfg,
	input  npcm_pkg::ctl_t      ctl,
	output npcm_pkg::sts_t      sts
);

	localparam int AW = npcm_pkg::PEAK_AW;
	localparam int MW = npcm_pkg::MUT_AW;
	localparam int CW = npcm_pkg::CNT_W;

	logic [npcm_pkg::COST_W-1:0] eps_q;
	logic [CW-1:0]               peaks_q;
	logic [CW-1:0]               n_w;
	logic [CW-1:0]               i_q, j_q, rcnt_q, scnt_q;
	logic [npcm_pkg::COST_W-1:0] ci_q, share_q;
	logic [AW-1:0]               o_q, oj_q, k_q;
	logic [npcm_pkg::MASK_W-1:0] mi_q, ra_q, rb_q, set_q;
	logic [npcm_pkg::DIST_W-1:0] d_q, best_q;
	logic                        out_valid_q, out_last_q;
	logic [AW-1:0]               out_idx_q;
	logic [npcm_pkg::COST_W-1:0] out_cost_q;

	// store ports
	logic                        da_we;
	logic [MW-1:0]               da_ra, db_ra;
	logic [npcm_pkg::DESC_W-1:0] da_rd, db_rd;
	logic                        c_we;
	logic [AW-1:0]               c_wa, c_ra;
	logic [npcm_pkg::COST_W-1:0] c_wd, c_rd;
	logic                        m_we;
	logic [AW-1:0]               m_ra;
	logic [npcm_pkg::MASK_W-1:0] m_rd;
	logic                        r_we;
	logic [AW-1:0]               r_ra;
	logic [AW-1:0]               r_rd;

	logic                        in_fire, out_fire;
	logic                        div_start, div_done;
	logic [npcm_pkg::COST_W-1:0] quot;
	logic [npcm_pkg::COST_W:0]   sum;
	logic                        lt_j;

	assign n_w = (peaks_q > CW'(npcm_pkg::MAX_PEAKS)) ? CW'(npcm_pkg::MAX_PEAKS) : peaks_q;

	assign item.ready = (ctl.op == npcm_pkg::OP_LOAD);
	assign in_fire    = item.valid && item.ready;
	assign out_fire   = out_valid_q && result.ready;
	assign cfg.ready  = 1'b1;

	assign sum  = {1'b0, c_rd} + {1'b0, share_q};
	assign lt_j = (c_rd < ci_q) || ((c_rd == ci_q) && (j_q < i_q));

	assign sts.run_start  = in_fire && (item.cmd == npcm_pkg::CMD_RUN);
	assign sts.n_zero     = (n_w == '0);
	assign sts.n_one      = (n_w == CW'(1));
	assign sts.j_end      = (j_q == n_w);
	assign sts.i_last     = (i_q == n_w - 1'b1);
	assign sts.walk_done  = (ra_q == '0) && (rb_q == '0);
	assign sts.skip       = (c_rd >= eps_q) || (scnt_q == '0);
	assign sts.div_done   = div_done;
	assign sts.set_empty  = (set_q == '0);
	assign sts.merge_last = ((i_q + CW'(2)) == n_w);
	assign sts.out_fire   = out_fire;
	assign sts.out_last   = out_last_q;

	assign div_start = (ctl.op == npcm_pkg::OP_M_CHK) && !sts.skip;

	always_comb begin
		da_we = in_fire && (item.cmd == npcm_pkg::CMD_LOAD_DESC);
		m_we  = in_fire && (item.cmd == npcm_pkg::CMD_LOAD_PEAK);
		c_we  = m_we;
		c_wa  = item.item_index[AW-1:0];
		c_wd  = item.cost;
		c_ra  = i_q[AW-1:0];
		m_ra  = r_rd;
		r_ra  = i_q[AW-1:0];
		r_we  = 1'b0;
		da_ra = npcm_pkg::low_idx(ra_q);
		db_ra = npcm_pkg::low_idx(rb_q);
		unique case (ctl.op)
			npcm_pkg::OP_SORT_RDJ: c_ra = j_q[AW-1:0];
			npcm_pkg::OP_SORT_WR:  r_we = 1'b1;
			npcm_pkg::OP_N_RDRJ:   r_ra = j_q[AW-1:0];
			npcm_pkg::OP_M_RDC:    c_ra = o_q;
			npcm_pkg::OP_M_ISSUE:  c_ra = npcm_pkg::low_idx(set_q);
			npcm_pkg::OP_M_ADD: begin
				c_we = 1'b1;
				c_wa = k_q;
				c_wd = sum[npcm_pkg::COST_W] ? '1 : sum[npcm_pkg::COST_W-1:0];
			end
			npcm_pkg::OP_M_ZERO: begin
				c_we = 1'b1;
				c_wa = o_q;
				c_wd = '0;
			end
			default: ;
		endcase
	end

	npcm_ram #(.WIDTH(npcm_pkg::DESC_W), .DEPTH(npcm_pkg::MAX_MUTATIONS)) u_desc_a (
		.clk(clk), .we(da_we), .waddr(item.item_index[MW-1:0]),
		.wdata({item.position, item.allele}), .raddr(da_ra), .rdata(da_rd));
	npcm_ram #(.WIDTH(npcm_pkg::DESC_W), .DEPTH(npcm_pkg::MAX_MUTATIONS)) u_desc_b (
		.clk(clk), .we(da_we), .waddr(item.item_index[MW-1:0]),
		.wdata({item.position, item.allele}), .raddr(db_ra), .rdata(db_rd));
	npcm_ram #(.WIDTH(npcm_pkg::COST_W), .DEPTH(npcm_pkg::MAX_PEAKS)) u_cost (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
	npcm_ram #(.WIDTH(npcm_pkg::MASK_W), .DEPTH(npcm_pkg::MAX_PEAKS)) u_mask (
		.clk(clk), .we(m_we), .waddr(item.item_index[AW-1:0]),
		.wdata(item.mutation_mask), .raddr(m_ra), .rdata(m_rd));
	npcm_ram #(.WIDTH(AW), .DEPTH(npcm_pkg::MAX_PEAKS)) u_rank (
		.clk(clk), .we(r_we), .waddr(rcnt_q[AW-1:0]), .wdata(i_q[AW-1:0]),
		.raddr(r_ra), .rdata(r_rd));

	npcm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(c_rd),
		.divisor(scnt_q), .done(div_done), .quot(quot));

	// config and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q       <= '0;
			peaks_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rcnt_q      <= '0;
			scnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == npcm_pkg::CFG_EPS) eps_q <= cfg.data;
				if (cfg.index == npcm_pkg::CFG_PEAKS) peaks_q <= cfg.data[CW-1:0];
			end
			unique case (ctl.op)
				npcm_pkg::OP_LOAD: if (sts.run_start) i_q <= '0;
				npcm_pkg::OP_SORT_RDI: begin
					j_q    <= '0;
					rcnt_q <= '0;
				end
				npcm_pkg::OP_SORT_CMP: begin
					j_q <= j_q + 1'b1;
					if (lt_j) rcnt_q <= rcnt_q + 1'b1;
				end
				npcm_pkg::OP_SORT_WR: i_q <= sts.i_last ? '0 : i_q + 1'b1;
				npcm_pkg::OP_N_LTMI: begin
					j_q    <= i_q + 1'b1;
					scnt_q <= '0;
				end
				npcm_pkg::OP_N_UPD: begin
					j_q <= j_q + 1'b1;
					if (d_q < best_q) scnt_q <= CW'(1);
					else if (d_q == best_q) scnt_q <= scnt_q + 1'b1;
				end
				npcm_pkg::OP_M_NEXT: i_q <= sts.merge_last ? '0 : i_q + 1'b1;
				npcm_pkg::OP_O_LAT: out_valid_q <= 1'b1;
				npcm_pkg::OP_O_WAIT: begin
					if (out_fire) begin
						out_valid_q <= 1'b0;
						i_q         <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			npcm_pkg::OP_SORT_LTI: ci_q <= c_rd;
			npcm_pkg::OP_N_RDMI:   o_q <= r_rd;
			npcm_pkg::OP_N_LTMI: begin
				mi_q   <= m_rd;
				best_q <= '1;
				set_q  <= '0;
			end
			npcm_pkg::OP_N_RDMJ: oj_q <= r_rd;
			npcm_pkg::OP_N_LTMJ: begin
				ra_q <= mi_q;
				rb_q <= m_rd;
				d_q  <= '0;
			end
			npcm_pkg::OP_W_STEP: begin
				// merge walk over the two sorted descriptor lists
				if (ra_q == '0) begin
					d_q  <= d_q + 1'b1;
					rb_q <= rb_q & (rb_q - 1'b1);
				end else if (rb_q == '0) begin
					d_q  <= d_q + 1'b1;
					ra_q <= ra_q & (ra_q - 1'b1);
				end else if (da_rd[npcm_pkg::DESC_W-1:npcm_pkg::ALL_W]
				             < db_rd[npcm_pkg::DESC_W-1:npcm_pkg::ALL_W]) begin
					d_q  <= d_q + 1'b1;
					ra_q <= ra_q & (ra_q - 1'b1);
				end else if (da_rd[npcm_pkg::DESC_W-1:npcm_pkg::ALL_W]
				             > db_rd[npcm_pkg::DESC_W-1:npcm_pkg::ALL_W]) begin
					d_q  <= d_q + 1'b1;
					rb_q <= rb_q & (rb_q - 1'b1);
				end else begin
					if (da_rd[npcm_pkg::ALL_W-1:0] != db_rd[npcm_pkg::ALL_W-1:0])
						d_q <= d_q + 1'b1;
					ra_q <= ra_q & (ra_q - 1'b1);
					rb_q <= rb_q & (rb_q - 1'b1);
				end
			end
			npcm_pkg::OP_N_UPD: begin
				if (d_q < best_q) begin
					best_q <= d_q;
					set_q  <= npcm_pkg::MASK_W'(1) << oj_q;
				end else if (d_q == best_q) begin
					set_q <= set_q | (npcm_pkg::MASK_W'(1) << oj_q);
				end
			end
			npcm_pkg::OP_M_DIV:   if (div_done) share_q <= quot;
			npcm_pkg::OP_M_ISSUE: k_q <= npcm_pkg::low_idx(set_q);
			npcm_pkg::OP_M_ADD:   set_q <= set_q & (set_q - 1'b1);
			npcm_pkg::OP_O_LAT: begin
				out_cost_q <= c_rd;
				out_idx_q  <= i_q[AW-1:0];
				out_last_q <= sts.i_last;
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.peak_index = out_idx_q;
	assign result.new_cost   = out_cost_q;
	assign result.last       = out_last_q;

	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ctl.op == npcm_pkg::OP_O_WAIT))
		else $error("result valid outside output wait");
	a_out_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.ready) |=> !out_valid_q)
		else $error("result not cleared after request taken");
	a_add_has_member: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == npcm_pkg::OP_M_ADD) |-> (set_q != '0))
		else $error("share added with empty nearest set");
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (ctl.op == npcm_pkg::OP_M_DIV))
		else $error("divider finished while not awaited");

endmodule

// ===== rtl/core/npcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcm_ctrl
// Run sequencer: load, rank sort, nearest set walk, merge, result drain.
// ----------------------------------------------------------------------------
module npcm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  npcm_pkg::sts_t sts,
	output npcm_pkg::ctl_t ctl
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_SORT_RDI = 5'd1;
	localparam logic [4:0] S_SORT_LTI = 5'd2;
	localparam logic [4:0] S_SORT_RDJ = 5'd3;
	localparam logic [4:0] S_SORT_CMP = 5'd4;
	localparam logic [4:0] S_SORT_WR  = 5'd5;
	localparam logic [4:0] S_N_RDRI   = 5'd6;
	localparam logic [4:0] S_N_RDMI   = 5'd7;
	localparam logic [4:0] S_N_LTMI   = 5'd8;
	localparam logic [4:0] S_N_RDRJ   = 5'd9;
	localparam logic [4:0] S_N_RDMJ   = 5'd10;
	localparam logic [4:0] S_N_LTMJ   = 5'd11;
	localparam logic [4:0] S_W_ISSUE  = 5'd12;
	localparam logic [4:0] S_W_STEP   = 5'd13;
	localparam logic [4:0] S_M_RDC    = 5'd14;
	localparam logic [4:0] S_M_CHK    = 5'd15;
	localparam logic [4:0] S_M_DIV    = 5'd16;
	localparam logic [4:0] S_M_ISSUE  = 5'd17;
	localparam logic [4:0] S_M_ADD    = 5'd18;
	localparam logic [4:0] S_M_NEXT   = 5'd19;
	localparam logic [4:0] S_O_RD     = 5'd20;
	localparam logic [4:0] S_O_LAT    = 5'd21;
	localparam logic [4:0] S_O_WAIT   = 5'd22;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl.op  = npcm_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				ctl.op = npcm_pkg::OP_LOAD;
				if (sts.run_start && !sts.n_zero) state_d = S_SORT_RDI;
			end
			S_SORT_RDI: begin
				ctl.op  = npcm_pkg::OP_SORT_RDI;
				state_d = S_SORT_LTI;
			end
			S_SORT_LTI: begin
				ctl.op  = npcm_pkg::OP_SORT_LTI;
				state_d = S_SORT_RDJ;
			end
			S_SORT_RDJ: begin
				if (sts.j_end) state_d = S_SORT_WR;
				else begin
					ctl.op  = npcm_pkg::OP_SORT_RDJ;
					state_d = S_SORT_CMP;
				end
			end
			S_SORT_CMP: begin
				ctl.op  = npcm_pkg::OP_SORT_CMP;
				state_d = S_SORT_RDJ;
			end
			S_SORT_WR: begin
				ctl.op = npcm_pkg::OP_SORT_WR;
				if (!sts.i_last) state_d = S_SORT_RDI;
				// a single peak has nothing to merge
				else if (sts.n_one) state_d = S_O_RD;
				else state_d = S_N_RDRI;
			end
			S_N_RDRI: begin
				ctl.op  = npcm_pkg::OP_N_RDRI;
				state_d = S_N_RDMI;
			end
			S_N_RDMI: begin
				ctl.op  = npcm_pkg::OP_N_RDMI;
				state_d = S_N_LTMI;
			end
			S_N_LTMI: begin
				ctl.op  = npcm_pkg::OP_N_LTMI;
				state_d = S_N_RDRJ;
			end
			S_N_RDRJ: begin
				if (sts.j_end) state_d = S_M_RDC;
				else begin
					ctl.op  = npcm_pkg::OP_N_RDRJ;
					state_d = S_N_RDMJ;
				end
			end
			S_N_RDMJ: begin
				ctl.op  = npcm_pkg::OP_N_RDMJ;
				state_d = S_N_LTMJ;
			end
			S_N_LTMJ: begin
				ctl.op  = npcm_pkg::OP_N_LTMJ;
				state_d = S_W_ISSUE;
			end
			S_W_ISSUE: begin
				if (sts.walk_done) begin
					ctl.op  = npcm_pkg::OP_N_UPD;
					state_d = S_N_RDRJ;
				end else begin
					ctl.op  = npcm_pkg::OP_W_ISSUE;
					state_d = S_W_STEP;
				end
			end
			S_W_STEP: begin
				ctl.op  = npcm_pkg::OP_W_STEP;
				state_d = S_W_ISSUE;
			end
			S_M_RDC: begin
				ctl.op  = npcm_pkg::OP_M_RDC;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				ctl.op  = npcm_pkg::OP_M_CHK;
				state_d = sts.skip ? S_M_NEXT : S_M_DIV;
			end
			S_M_DIV: begin
				ctl.op = npcm_pkg::OP_M_DIV;
				if (sts.div_done) state_d = S_M_ISSUE;
			end
			S_M_ISSUE: begin
				if (sts.set_empty) begin
					ctl.op  = npcm_pkg::OP_M_ZERO;
					state_d = S_M_NEXT;
				end else begin
					ctl.op  = npcm_pkg::OP_M_ISSUE;
					state_d = S_M_ADD;
				end
			end
			S_M_ADD: begin
				ctl.op  = npcm_pkg::OP_M_ADD;
				state_d = S_M_ISSUE;
			end
			S_M_NEXT: begin
				ctl.op  = npcm_pkg::OP_M_NEXT;
				state_d = sts.merge_last ? S_O_RD : S_N_RDRI;
			end
			S_O_RD: begin
				ctl.op  = npcm_pkg::OP_O_RD;
				state_d = S_O_LAT;
			end
			S_O_LAT: begin
				ctl.op  = npcm_pkg::OP_O_LAT;
				state_d = S_O_WAIT;
			end
			S_O_WAIT: begin
				ctl.op = npcm_pkg::OP_O_WAIT;
				if (sts.out_fire) state_d = sts.out_last ? S_IDLE : S_O_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_sort_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && sts.run_start && !sts.n_zero) |=> (state_q == S_SORT_RDI))
		else $error("run did not start sort");
	a_merge_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_DIV && sts.div_done) |=> (state_q == S_M_ISSUE))
		else $error("share not applied after divide");
	a_drain_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_O_WAIT && sts.out_fire && sts.out_last) |=> (state_q == S_IDLE))
		else $error("run did not end on last result");

endmodule

// ===== rtl/core/nearest_peak_cost_merging_core.sv =====
// ----------------------------------------------------------------------------
// nearest_peak_cost_merging_core
// Load descriptors and peaks one request per cycle; a run request ranks the
// peaks, merges cheap peaks into their nearest later peaks, then drains costs.
// ----------------------------------------------------------------------------
// Loads: one request per cycle, no result.
// Run: the peaks are ranked, then each pair is compared by a walk over its
//   descriptors; each merged peak is divided, then adds its share to each receiving peak.
// Results: each is read, latched and held until taken; input is held off for the whole run.
// Reset: asynchronous, clears config and control; stores are undefined.
// ----------------------------------------------------------------------------
module nearest_peak_cost_merging_core (
	input  logic       clk,
	input  logic       arst_n,
	npcm_in_if.sink    item,
	npcm_out_if.source result,
	npcm_cfg_if.sink   cfg
);

	npcm_pkg::ctl_t ctl;
	npcm_pkg::sts_t sts;

	npcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .ctl(ctl));

	npcm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg),
		.ctl(ctl), .sts(sts));

endmodule

// ===== bench/tb_nearest_peak_cost_merging_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_peak_cost_merging_core
// Fills the descriptor and peak stores, walks a table of directed requests,
// then random rounds of loads, register writes and runs. Every result is
// compared against a behavioral predictor of ranking, nearest sets and merging.
// ----------------------------------------------------------------------------
module tb_nearest_peak_cost_merging_core;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 470;

	typedef struct {
		logic [5:0]  peak_index;
		logic [31:0] new_cost;
		logic        last;
	} cost_report_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  code;
		logic [5:0]  idx;
		logic [23:0] pos;
		logic [7:0]  al;
		logic [31:0] cost;
		logic [63:0] mask;
		bit          typed;
		logic [31:0] typed_cost;
	} step_t;

	logic clk;
	logic arst_n;
	npcm_in_if  in_ch();
	npcm_out_if out_ch();
	npcm_cfg_if cfg_ch();

	nearest_peak_cost_merging_core uut (
		.clk(clk), .arst_n(arst_n), .item(in_ch.sink), .result(out_ch.source), .cfg(cfg_ch.sink)
	);

	// shadow of the block
	logic [23:0] ds_pos [64];
	logic [7:0]  ds_al [64];
	logic [31:0] pk_cost [64];
	logic [63:0] pk_mask [64];
	logic [31:0] eps_r;
	logic [6:0]  npk_r;

	cost_report_t expected_costs[$];
	int errors = 0;
	int items_sent = 0;
	int hold_req = 0;
	bit calm = 0;

	initial clk = 0;
	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int unsigned merge_dist(input logic [63:0] a, input logic [63:0] b);
		int la[64];
		int lb[64];
		int na, nb, i, j, d;
		na = 0; nb = 0; i = 0; j = 0; d = 0;
		for (int k = 0; k < 64; k++) begin
			if (a[k]) begin la[na] = k; na++; end
			if (b[k]) begin lb[nb] = k; nb++; end
		end
		while (i < na || j < nb) begin
			if (i == na) begin d++; j++; end
			else if (j == nb) begin d++; i++; end
			else if (ds_pos[la[i]] < ds_pos[lb[j]]) begin d++; i++; end
			else if (ds_pos[la[i]] > ds_pos[lb[j]]) begin d++; j++; end
			else begin
				if (ds_al[la[i]] != ds_al[lb[j]]) d++;
				i++; j++;
			end
		end
		return d;
	endfunction

	// rank, find nearest sets, merge cheap peaks, queue the final costs
	task automatic predict_merge_run();
		int rank[64];
		logic [63:0] nset[64];
		int n, key, j, cnt, o;
		int unsigned best, d;
		logic [31:0] share;
		logic [32:0] sum;
		cost_report_t r;
		n = (npk_r > 64) ? 64 : npk_r;
		if (n == 0) return;
		for (int i = 0; i < n; i++) rank[i] = i;
		for (int i = 1; i < n; i++) begin
			key = rank[i];
			j = i;
			while (j > 0 && pk_cost[rank[j-1]] > pk_cost[key]) begin
				rank[j] = rank[j-1];
				j--;
			end
			rank[j] = key;
		end
		for (int i = 0; i < n; i++) begin
			best = 32'hFFFF_FFFF;
			nset[i] = '0;
			for (int m = i + 1; m < n; m++) begin
				d = merge_dist(pk_mask[rank[i]], pk_mask[rank[m]]);
				if (d < best) begin best = d; nset[i] = 64'd1 << rank[m]; end
				else if (d == best) nset[i][rank[m]] = 1'b1;
			end
		end
		for (int i = 0; i + 1 < n; i++) begin
			o = rank[i];
			if (pk_cost[o] >= eps_r) continue;
			cnt = $countones(nset[i]);
			if (cnt == 0) continue;
			share = pk_cost[o] / cnt;
			for (int k = 0; k < 64; k++) begin
				if (nset[i][k]) begin
					sum = {1'b0, pk_cost[k]} + share;
					pk_cost[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			pk_cost[o] = '0;
		end
		for (int i = 0; i < n; i++) begin
			r.peak_index = i[5:0];
			r.new_cost = pk_cost[i];
			r.last = (i + 1 == n);
			expected_costs.push_back(r);
		end
	endtask

	// result side: random stalls, long hold-offs on request
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_costs.size() == 0) begin
					report($sformatf("unexpected result peak %0d", out_ch.peak_index));
				end else begin
					cost_report_t e;
					e = expected_costs.pop_front();
					if (out_ch.peak_index !== e.peak_index)
						report($sformatf("peak_index %0d, want %0d", out_ch.peak_index,
							e.peak_index));
					if (out_ch.new_cost !== e.new_cost)
						report($sformatf("peak %0d new_cost %h, want %h", e.peak_index,
							out_ch.new_cost, e.new_cost));
					if (out_ch.last !== e.last)
						report($sformatf("peak %0d last %b, want %b", e.peak_index,
							out_ch.last, e.last));
				end
			end
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70) out_ch.ready <= 1'b1;
				else begin
					out_ch.ready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
				end
			end
		end
	end

	// watchdog: cycles with no accepted request on any channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic wait_drain();
		while (expected_costs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		wait_drain();
		// a run with no results or a trailing load may still be in flight
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == npcm_pkg::CFG_EPS) eps_r = data;
		else if (idx == npcm_pkg::CFG_PEAKS) npk_r = data[6:0];
		cfg_ch.valid <= 1'b0;
	endtask

	// leaves valid high after acceptance; the next request or idle lowers it
	task automatic send_item(input logic [1:0] cmd, input logic [5:0] idx,
			input logic [23:0] pos, input logic [7:0] al, input logic [31:0] cost,
			input logic [63:0] mask);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.item_index <= idx;
		in_ch.position <= pos;
		in_ch.allele <= al;
		in_ch.cost <= cost;
		in_ch.mutation_mask <= mask;
		do @(posedge clk); while (!in_ch.ready);
		case (cmd)
			npcm_pkg::CMD_LOAD_DESC: begin ds_pos[idx] = pos; ds_al[idx] = al; end
			npcm_pkg::CMD_LOAD_PEAK: begin pk_cost[idx] = cost; pk_mask[idx] = mask; end
			npcm_pkg::CMD_RUN: predict_merge_run();
			default: ;
		endcase
		if (cmd != CMD_UNUSED) items_sent++;
	endtask

	task automatic stop_items();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] sparse_mask();
		logic [63:0] m;
		m = '0;
		repeat ($urandom_range(1, 6)) m[$urandom_range(0, 63)] = 1'b1;
		return m;
	endfunction

	function automatic logic [31:0] rand_cost();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 32'h0001_0000 * $urandom_range(0, 3);
		if (r == 3) return 32'hFFFF_FFFF - $urandom_range(0, 3);
		return $urandom;
	endfunction

	function automatic step_t row(input bit is_cfg, input logic [1:0] code,
			input logic [5:0] idx, input logic [23:0] pos, input logic [7:0] al,
			input logic [31:0] cost, input logic [63:0] mask, input bit typed,
			input logic [31:0] typed_cost);
		step_t s;
		s.is_cfg = is_cfg; s.code = code; s.idx = idx; s.pos = pos; s.al = al;
		s.cost = cost; s.mask = mask; s.typed = typed; s.typed_cost = typed_cost;
		return s;
	endfunction

	initial begin
		step_t steps[$];
		logic [23:0] base;
		int round;
		in_ch.valid = 1'b0;
		in_ch.cmd = npcm_pkg::CMD_LOAD_DESC;
		in_ch.item_index = '0;
		in_ch.position = '0;
		in_ch.allele = '0;
		in_ch.cost = '0;
		in_ch.mutation_mask = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = npcm_pkg::CFG_EPS;
		cfg_ch.data = '0;
		eps_r = '0;
		npk_r = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot so no run ever reads an unwritten entry;
		// pairs of descriptors share a position, some with different alleles
		base = 24'd100;
		for (int k = 0; k < 64; k++) begin
			if (k % 2 == 0) base = base + 24'($urandom_range(1, 5000));
			send_item(npcm_pkg::CMD_LOAD_DESC, k[5:0], base, 8'(65 + $urandom_range(0, 3)),
				'0, '0);
		end
		for (int k = 0; k < 64; k++)
			send_item(npcm_pkg::CMD_LOAD_PEAK, k[5:0], '0, '0, rand_cost(), sparse_mask());

		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd0, '0, '0, 32'hFFFF_FFFF, '1, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_PEAKS, '0, '0, '0, 32'd1, '0, 0, '0));
		// a single peak is last ranked and never merged
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 1, 32'hFFFF_FFFF));
		steps.push_back(row(0, CMD_UNUSED, 6'd63, '1, '1, '1, '1, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_DESC, 6'd63, 24'hFFFFFF, 8'hFF, '0, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_DESC, 6'd0, 24'd0, 8'd0, '0, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd1, '0, '0, 32'd0, 64'd0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd2, '0, '0, 32'd1, 64'd1 << 63, 0,
			'0));
		steps.push_back(row(1, npcm_pkg::CFG_EPS, '0, '0, '0, 32'hFFFF_FFFF, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_PEAKS, '0, '0, '0, 32'd3, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd1, '0, '0, 32'hFFFF_FFFE, 64'd1, 0,
			'0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd2, '0, '0, 32'hFFFF_FFFE, 64'd1, 0,
			'0));
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_PEAKS, '0, '0, '0, 32'd0, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_PEAKS, '0, '0, '0, 32'd127, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_EPS, '0, '0, '0, 32'h0002_0000, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_LOAD_PEAK, 6'd0, '0, '0, 32'h0001_0000, 64'h5, 0,
			'0));
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_PEAKS, '0, '0, '0, 32'd64, '0, 0, '0));
		steps.push_back(row(1, npcm_pkg::CFG_EPS, '0, '0, '0, 32'd0, '0, 0, '0));
		steps.push_back(row(0, npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0, 0, '0));

		foreach (steps[s]) begin
			if (steps[s].is_cfg) begin
				stop_items();
				write_reg(steps[s].code, steps[s].cost);
			end else begin
				send_item(steps[s].code, steps[s].idx, steps[s].pos, steps[s].al,
					steps[s].cost, steps[s].mask);
				if (steps[s].typed) expected_costs[$].new_cost = steps[s].typed_cost;
			end
		end

		round = 0;
		while (items_sent < ITEM_TARGET) begin
			int r;
			round++;
			calm = ($urandom_range(0, 3) == 0);
			stop_items();
			r = $urandom_range(0, 9);
			// the hold-off round needs a run that gives results
			if (round == 6) r = 0;
			if (r < 7) write_reg(npcm_pkg::CFG_PEAKS, $urandom_range(1, 8));
			else if (r == 7) write_reg(npcm_pkg::CFG_PEAKS, 32'd0);
			else if (r == 8) write_reg(npcm_pkg::CFG_PEAKS, $urandom_range(9, 20));
			else write_reg(npcm_pkg::CFG_PEAKS, $urandom_range(64, 127));
			r = $urandom_range(0, 5);
			if (r == 0) write_reg(npcm_pkg::CFG_EPS, 32'd0);
			else if (r == 1) write_reg(npcm_pkg::CFG_EPS, 32'hFFFF_FFFF);
			else if (r == 2) write_reg(npcm_pkg::CFG_EPS, $urandom);
			else write_reg(npcm_pkg::CFG_EPS, 32'h0001_0000 * $urandom_range(1, 4));
			repeat ($urandom_range(3, 12)) begin
				int k;
				logic [5:0] idx;
				k = $urandom_range(0, 19);
				idx = (npk_r <= 20) ? 6'($urandom_range(0, 19)) : 6'($urandom_range(0, 63));
				if (k < 4) begin
					idx = 6'($urandom_range(0, 63));
					send_item(npcm_pkg::CMD_LOAD_DESC, idx, 24'($urandom), 8'($urandom),
						$urandom, {$urandom, $urandom});
				end else if (k == 4) begin
					send_item(CMD_UNUSED, 6'($urandom), 24'($urandom), 8'($urandom), $urandom,
						{$urandom, $urandom});
				end else if (k == 5 && npk_r <= 8) begin
					send_item(npcm_pkg::CMD_LOAD_PEAK, idx, 24'($urandom), 8'($urandom),
						rand_cost(), {$urandom, $urandom});
				end else begin
					send_item(npcm_pkg::CMD_LOAD_PEAK, idx, 24'($urandom), 8'($urandom),
						rand_cost(), sparse_mask());
				end
			end
			if (round == 6) begin
				// hold the result side while requests keep coming
				hold_req = 600;
				send_item(npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0);
				repeat (4) send_item(npcm_pkg::CMD_LOAD_DESC, 6'($urandom_range(0, 63)),
					24'($urandom), 8'($urandom), $urandom, '0);
			end else if (round == 9) begin
				stop_items();
				wait_drain();
				send_item(npcm_pkg::CMD_RUN, '0, '0, '0, '0, '0);
			end else begin
				send_item(npcm_pkg::CMD_RUN, 6'($urandom), 24'($urandom), 8'($urandom),
					$urandom, {$urandom, $urandom});
			end
		end
		stop_items();
		wait_drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
